/* src/multi_channel_tick_timer_bank_macros.svh */
// ---------------------------------------------------------------------------
// multi_channel_tick_timer_bank assertion macros
// Shared concurrent assertion forms used by the timer bank checker.
// ---------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_TICK_TIMER_BANK_MACROS_SVH
`define MULTI_CHANNEL_TICK_TIMER_BANK_MACROS_SVH

// same-cycle implication, disabled in reset
`define MCTT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define MCTT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/mctt_pkg.sv */
// ---------------------------------------------------------------------------
// mctt_pkg
// Types and constants of the multi-channel tick timer bank.
// ---------------------------------------------------------------------------
`default_nettype none

package mctt_pkg;

   localparam int NumTimersDef = 32;
   localparam int TimerIdW     = 5;
   localparam int PeriodW      = 32;
   localparam int RunTimeW     = 31;
   localparam int FuncW        = 3;
   localparam int KindW        = 2;

   localparam logic [RunTimeW-1:0] RunWrap = 31'h7FFF_FFFF;

   // request function codes
   localparam logic [FuncW-1:0] FUNC_TICK  = 3'd0;
   localparam logic [FuncW-1:0] FUNC_START = 3'd1;
   localparam logic [FuncW-1:0] FUNC_STOP  = 3'd2;
   localparam logic [FuncW-1:0] FUNC_POLL  = 3'd3;
   localparam logic [FuncW-1:0] FUNC_READ  = 3'd4;

   // result kinds
   localparam logic [KindW-1:0] KIND_NONE  = 2'd0;
   localparam logic [KindW-1:0] KIND_FIRED = 2'd1;
   localparam logic [KindW-1:0] KIND_RUN   = 2'd2;

   typedef struct packed {
      logic [FuncW-1:0]    func;
      logic [TimerIdW-1:0] timer_id;
      logic [PeriodW-1:0]  period;
      logic                reload_en;
      logic                notify;
   } req_type;

   typedef struct packed {
      logic [KindW-1:0]    kind;
      logic [TimerIdW-1:0] fired_id;
      logic [RunTimeW-1:0] run_time;
      logic                last;
   } rsp_type;

   // one timer entry as stored in the memory
   typedef struct packed {
      logic [PeriodW-1:0] remaining;
      logic [PeriodW-1:0] reload_value;
      logic               expired;
      logic               periodic;
      logic               report_en;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_POLL_END,
      ST_READ
   } state_type;

endpackage

`default_nettype wire

/* src/mctt_ram.sv */
// ---------------------------------------------------------------------------
// mctt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module mctt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/multi_channel_tick_timer_bank.sv */
// ---------------------------------------------------------------------------
// multi_channel_tick_timer_bank
// Bank of countdown timers on a shared tick, with one-shot and auto-reload
// modes, polled expiry reporting and a 31-bit run-time counter.
// ---------------------------------------------------------------------------
// Timer entries live in one memory with a registered read and are walked one
// entry per cycle, unless a poll stalls while rsp_ready is held low with a
// fired id waiting. Start and stop are done from idle. Tick sweeps through
// the memory. Poll sweeps through the memory, then hands its last result to
// the result register once it is free. Read run time passes through a read
// state to the result register once that register is free. A new request is
// taken only when the previous one has finished; the result register lets a
// request be taken while the last result waits.
`default_nettype none

module multi_channel_tick_timer_bank
   import mctt_pkg::*;
#(
   parameter int NUM_TIMERS = NumTimersDef
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int EntryW = $bits(entry_type);

   state_type               state_ff, state_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic                    poll_ff, poll_in;
   logic [NUM_TIMERS-1:0]   active_ff, active_in;
   logic [RunTimeW-1:0]     total_ff, total_in;
   logic                    pend_vld_ff, pend_vld_in;
   logic [AW-1:0]           pend_id_ff, pend_id_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                    ram_wr_en;
   logic [AW-1:0]           ram_wr_addr;
   entry_type               wr_ent;
   logic                    ram_rd_en;
   logic [AW-1:0]           ram_rd_addr;
   logic [EntryW-1:0]       ram_rd_data;
   entry_type               rd_ent;

   logic                    out_free;
   logic                    id_ok;
   logic [RunTimeW-1:0]     total_inc;
   logic                    act;
   logic                    hit;
   logic                    emit;
   logic                    advance;
   logic [PeriodW-1:0]      rem_dec;

   mctt_ram #(
      .WIDTH (EntryW),
      .DEPTH (NUM_TIMERS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (wr_ent),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_ent    = entry_type'(ram_rd_data);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign id_ok     = ({1'b0, req_data.timer_id} < (TimerIdW+1)'(NUM_TIMERS));
   assign total_inc = total_ff + 1'b1;
   assign rem_dec   = rd_ent.remaining - 1'b1;
   assign act       = active_ff[idx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         total_ff     <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         total_ff     <= total_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      poll_ff     <= poll_in;
      pend_id_ff  <= pend_id_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      poll_in      = poll_ff;
      active_in    = active_ff;
      total_in     = total_ff;
      pend_vld_in  = pend_vld_ff;
      pend_id_in   = pend_id_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff;
      wr_ent       = rd_ent;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = idx_ff + AW'(1);
      hit          = 1'b0;
      emit         = 1'b0;
      advance      = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_data.func)
                  FUNC_TICK: begin
                     total_in    = (total_inc == RunWrap) ? '0 : total_inc;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     idx_in      = '0;
                     poll_in     = 1'b0;
                     state_in    = ST_SWEEP;
                  end
                  FUNC_START: begin
                     if (id_ok) begin
                        ram_wr_en              = 1'b1;
                        ram_wr_addr            = req_data.timer_id[AW-1:0];
                        wr_ent.remaining       = req_data.period;
                        wr_ent.reload_value    = req_data.period;
                        wr_ent.expired         = 1'b0;
                        wr_ent.periodic        = req_data.reload_en;
                        wr_ent.report_en       = req_data.notify;
                        active_in[ram_wr_addr] = 1'b1;
                     end
                  end
                  FUNC_STOP: begin
                     if (id_ok) begin
                        ram_wr_en              = 1'b1;
                        ram_wr_addr            = req_data.timer_id[AW-1:0];
                        wr_ent                 = '0;
                        active_in[ram_wr_addr] = 1'b0;
                     end
                  end
                  FUNC_POLL: begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     idx_in      = '0;
                     poll_in     = 1'b1;
                     pend_vld_in = 1'b0;
                     state_in    = ST_SWEEP;
                  end
                  FUNC_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SWEEP: begin
            if (!poll_ff) begin
               // tick: count down, flag and reload on reaching zero
               advance   = 1'b1;
               ram_wr_en = act && (rd_ent.remaining != '0);
               wr_ent.remaining = rem_dec;
               if (rem_dec == '0) begin
                  wr_ent.expired = 1'b1;
                  if (rd_ent.periodic) begin
                     wr_ent.remaining = rd_ent.reload_value;
                  end
               end
            end else begin
               // poll: hold one fired id back so the final one gets last
               hit            = act && rd_ent.expired;
               emit           = hit && rd_ent.report_en;
               advance        = !(emit && pend_vld_ff && !out_free);
               ram_wr_en      = hit && advance;
               wr_ent.expired = 1'b0;
               if (advance && emit) begin
                  if (pend_vld_ff) begin
                     rsp_valid_in         = 1'b1;
                     rsp_data_in.kind     = KIND_FIRED;
                     rsp_data_in.fired_id = TimerIdW'(pend_id_ff);
                     rsp_data_in.run_time = '0;
                     rsp_data_in.last     = 1'b0;
                  end
                  pend_vld_in = 1'b1;
                  pend_id_in  = idx_ff;
               end
            end
            if (advance) begin
               if (idx_ff == AW'(NUM_TIMERS - 1)) begin
                  state_in = poll_ff ? ST_POLL_END : ST_IDLE;
               end else begin
                  idx_in    = idx_ff + AW'(1);
                  ram_rd_en = 1'b1;
               end
            end
         end

         ST_POLL_END: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.kind     = pend_vld_ff ? KIND_FIRED : KIND_NONE;
               rsp_data_in.fired_id = pend_vld_ff ? TimerIdW'(pend_id_ff) : '0;
               rsp_data_in.run_time = '0;
               rsp_data_in.last     = 1'b1;
               pend_vld_in          = 1'b0;
               state_in             = ST_IDLE;
            end
         end

         ST_READ: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.kind     = KIND_RUN;
               rsp_data_in.fired_id = '0;
               rsp_data_in.run_time = total_ff;
               rsp_data_in.last     = 1'b1;
               state_in             = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* src/mctt_checker.sv */
// ---------------------------------------------------------------------------
// mctt_checker
// Port-level checks on the timer bank, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "multi_channel_tick_timer_bank_macros.svh"

module mctt_checker
   import mctt_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   `MCTT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")
   `MCTT_ASSERT_IMPL(a_kind_legal, clock, reset, rsp_valid, (rsp_data.kind == KIND_NONE) || (rsp_data.kind == KIND_FIRED) || (rsp_data.kind == KIND_RUN), "illegal result kind")
   `MCTT_ASSERT_IMPL(a_single_last, clock, reset, rsp_valid && (rsp_data.kind != KIND_FIRED), rsp_data.last && (rsp_data.fired_id == '0), "single result not marked last")
   `MCTT_ASSERT_IMPL(a_run_zero, clock, reset, rsp_valid && (rsp_data.kind != KIND_RUN), rsp_data.run_time == '0, "run time set on non-read result")
   `MCTT_ASSERT_NEXT(a_read_blocks, clock, reset, req_valid && req_ready && (req_data.func == FUNC_READ), !req_ready, "request taken while read is pending")

endmodule

bind multi_channel_tick_timer_bank mctt_checker u_mctt_checker (.*);

`default_nettype wire

/* tb/timer_bank_checker.sv */
// ---------------------------------------------------------------------------
// timer_bank_checker
// Watches the request and result channels of the tick timer bank, keeps its
// own copy of the timer state, works out the results each accepted request
// should cause and compares them in order with the results that come out.
// ---------------------------------------------------------------------------
module timer_bank_checker
   import mctt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      rsp_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NT        = NumTimersDef;
   localparam int ReportMax = 10;

   logic [PeriodW-1:0]  count_left [NT];
   logic [PeriodW-1:0]  reload_val [NT];
   logic [NT-1:0]       flag_up;
   logic [NT-1:0]       auto_mode;
   logic [NT-1:0]       notify_en;
   logic [NT-1:0]       armed;
   logic [RunTimeW-1:0] ticks;
   rsp_type             pending_rsp [$];
   int                  rsp_seen;

   task automatic apply_request(input req_type r);
      rsp_type item;
      int      hits;
      item = '0;
      hits = 0;
      case (r.func)
         FUNC_TICK: begin
            for (int i = 0; i < NT; i++) begin
               if (armed[i] && count_left[i] != '0) begin
                  count_left[i] = count_left[i] - 1'b1;
                  if (count_left[i] == '0) begin
                     flag_up[i] = 1'b1;
                     if (auto_mode[i]) count_left[i] = reload_val[i];
                  end
               end
            end
            ticks = ticks + 1'b1;
            // run time skips the all-ones value
            if (ticks == RunWrap) ticks = '0;
         end
         FUNC_START: begin
            count_left[r.timer_id] = r.period;
            reload_val[r.timer_id] = r.period;
            flag_up[r.timer_id]    = 1'b0;
            auto_mode[r.timer_id]  = r.reload_en;
            notify_en[r.timer_id]  = r.notify;
            armed[r.timer_id]      = 1'b1;
         end
         FUNC_STOP: begin
            count_left[r.timer_id] = '0;
            reload_val[r.timer_id] = '0;
            flag_up[r.timer_id]    = 1'b0;
            auto_mode[r.timer_id]  = 1'b0;
            notify_en[r.timer_id]  = 1'b0;
            armed[r.timer_id]      = 1'b0;
         end
         FUNC_POLL: begin
            for (int i = 0; i < NT; i++) begin
               if (armed[i] && flag_up[i]) begin
                  flag_up[i] = 1'b0;
                  // silent timers lose the flag without a report
                  if (notify_en[i]) begin
                     item          = '0;
                     item.kind     = KIND_FIRED;
                     item.fired_id = TimerIdW'(i);
                     pending_rsp.push_back(item);
                     hits++;
                  end
               end
            end
            if (hits == 0) begin
               item      = '0;
               item.kind = KIND_NONE;
               item.last = 1'b1;
               pending_rsp.push_back(item);
            end else begin
               item      = pending_rsp.pop_back();
               item.last = 1'b1;
               pending_rsp.push_back(item);
            end
         end
         FUNC_READ: begin
            item.kind     = KIND_RUN;
            item.run_time = ticks;
            item.last     = 1'b1;
            pending_rsp.push_back(item);
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < NT; i++) begin
            count_left[i] = '0;
            reload_val[i] = '0;
         end
         flag_up    = '0;
         auto_mode  = '0;
         notify_en  = '0;
         armed      = '0;
         ticks      = '0;
         rsp_seen   = 0;
         mismatches = 0;
         pending_rsp.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               if (mismatches < ReportMax) begin
                  $display("result %0d with nothing owed: kind %0d id %0d run %0d last %0d",
                           rsp_seen, rsp_data.kind, rsp_data.fired_id, rsp_data.run_time,
                           rsp_data.last);
               end
               mismatches++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.kind !== want.kind || rsp_data.fired_id !== want.fired_id ||
                   rsp_data.run_time !== want.run_time || rsp_data.last !== want.last) begin
                  if (mismatches < ReportMax) begin
                     // fields shown as kind/id/run_time/last
                     $display("result %0d: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                              rsp_seen, want.kind, want.fired_id, want.run_time, want.last,
                              rsp_data.kind, rsp_data.fired_id, rsp_data.run_time,
                              rsp_data.last);
                  end
                  mismatches++;
               end
            end
            rsp_seen++;
         end
         if (req_valid && req_ready) apply_request(req_data);
      end
      rsp_owed <= pending_rsp.size();
   end

endmodule

/* tb/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Stimulus for the tick timer bank: a directed opening on the corner cases,
// then random start, stop, tick, poll and read requests with idle bursts on
// both channels, a long result hold-off and a final stretch at full rate.
// ---------------------------------------------------------------------------
module tb
   import mctt_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ClkPeriod   = 12;
   localparam int ResetCycles = 9;
   localparam int HoldCycles  = 400;
   localparam int StallLimit  = 6000;
   localparam int TailCycles  = 80;

   localparam logic [FuncW-1:0]   FUNC_LAST = '1;
   localparam logic [PeriodW-1:0] PER_MAX   = '1;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      mismatches;
   int      rsp_owed;
   int      sent      = 0;
   bit      idling    = 1'b1;
   bit      hold_ask  = 1'b0;
   bit      hold_done = 1'b0;

   multi_channel_tick_timer_bank dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   timer_bank_checker bank_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .mismatches (mismatches),
      .rsp_owed   (rsp_owed)
   );

   initial begin
      forever #(ClkPeriod / 2) clock = ~clock;
   end

   // result side: idle bursts, plus one long hold-off on request
   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (hold_ask && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_done = 1'b1;
         end else if (idling && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < StallLimit) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   function automatic req_type mk(input logic [FuncW-1:0] f, input int id,
                                  input logic [PeriodW-1:0] per, input logic ar,
                                  input logic nt);
      req_type r;
      r.func      = f;
      r.timer_id  = TimerIdW'(id);
      r.period    = per;
      r.reload_en = ar;
      r.notify    = nt;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type     r;
      int          pick;
      int          sel;
      logic [31:0] word;
      word        = $urandom;
      r.timer_id  = word[4:0];
      r.reload_en = word[5];
      r.notify    = word[6];
      r.period    = $urandom;
      pick        = $urandom_range(0, 99);
      if (pick < 38) r.func = FUNC_TICK;
      else if (pick < 60) r.func = FUNC_START;
      else if (pick < 70) r.func = FUNC_STOP;
      else if (pick < 84) r.func = FUNC_POLL;
      else if (pick < 95) r.func = FUNC_READ;
      else r.func = FuncW'($urandom_range(FUNC_READ + 1, FUNC_LAST));
      if (r.func == FUNC_START) begin
         sel = $urandom_range(0, 19);
         // mostly short periods so timers actually expire
         if (sel < 11) r.period = PeriodW'($urandom_range(1, 4));
         else if (sel < 15) r.period = PeriodW'($urandom_range(5, 40));
         else if (sel < 17) r.period = '0;
      end
      return r;
   endfunction

   task automatic send(input req_type r);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (r.func <= FUNC_READ) sent++;
   endtask

   // start a run of consecutive timers from a random base
   task automatic arm_batch(input int k, input int per_hi, input logic all_notify);
      int   base;
      logic nt;
      base = $urandom_range(0, NumTimersDef - 1);
      for (int j = 0; j < k; j++) begin
         nt = all_notify ? 1'b1 : 1'($urandom_range(0, 1));
         send(mk(FUNC_START, (base + j) % NumTimersDef,
                 PeriodW'($urandom_range(1, per_hi)), 1'($urandom_range(0, 1)), nt));
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rsp_owed != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // state straight out of reset
      send(mk(FUNC_READ, 0, '0, 1'b0, 1'b0));
      send(mk(FUNC_POLL, 31, PER_MAX, 1'b1, 1'b1));
      send(mk(FuncW'(FUNC_READ + 1), 7, PER_MAX, 1'b1, 1'b1));
      send(mk(FUNC_LAST, 0, '0, 1'b0, 1'b0));
      // period zero, one-shot, silent, auto-reload and longest period
      send(mk(FUNC_START, 0, '0, 1'b1, 1'b1));
      send(mk(FUNC_START, 31, 32'd1, 1'b0, 1'b1));
      send(mk(FUNC_START, 7, 32'd1, 1'b0, 1'b0));
      send(mk(FUNC_START, 12, 32'd2, 1'b1, 1'b1));
      send(mk(FUNC_START, 20, PER_MAX, 1'b1, 1'b1));
      send(mk(FUNC_TICK, 0, '0, 1'b0, 1'b0));
      send(mk(FUNC_POLL, 0, '0, 1'b0, 1'b0));
      send(mk(FUNC_POLL, 0, '0, 1'b0, 1'b0));
      send(mk(FUNC_TICK, 31, PER_MAX, 1'b1, 1'b1));
      // restart drops a raised flag before it is polled
      send(mk(FUNC_START, 12, 32'd2, 1'b1, 1'b1));
      send(mk(FUNC_POLL, 0, '0, 1'b0, 1'b0));
      send(mk(FUNC_TICK, 0, '0, 1'b0, 1'b0));
      send(mk(FUNC_TICK, 0, '0, 1'b0, 1'b0));
      send(mk(FUNC_POLL, 0, '0, 1'b0, 1'b0));
      send(mk(FUNC_STOP, 12, PER_MAX, 1'b1, 1'b1));
      send(mk(FUNC_TICK, 0, '0, 1'b0, 1'b0));
      send(mk(FUNC_POLL, 0, '0, 1'b0, 1'b0));
      send(mk(FUNC_READ, 31, PER_MAX, 1'b1, 1'b1));
      send(mk(FUNC_STOP, 31, '0, 1'b0, 1'b0));
      send(mk(FUNC_STOP, 0, PER_MAX, 1'b1, 1'b1));

      while (sent < 75) begin
         if ($urandom_range(0, 9) == 0) arm_batch($urandom_range(2, 6), 3, 1'b0);
         else send(random_request());
      end

      // let everything come out before the pressure phase
      wait_drained();

      // every timer fires on one tick, results held back so the bank backs up
      arm_batch(NumTimersDef, 1, 1'b1);
      hold_ask = 1'b1;
      send(mk(FUNC_TICK, 0, '0, 1'b0, 1'b0));
      send(mk(FUNC_POLL, 0, '0, 1'b0, 1'b0));
      send(mk(FUNC_READ, 0, '0, 1'b0, 1'b0));
      send(mk(FUNC_POLL, 0, '0, 1'b0, 1'b0));
      send(mk(FUNC_READ, 0, '0, 1'b0, 1'b0));
      wait_drained();

      idling = 1'b0;
      while (sent < 125) begin
         if ($urandom_range(0, 9) == 0) arm_batch($urandom_range(2, 6), 3, 1'b0);
         else send(random_request());
      end
      send(mk(FUNC_POLL, 0, '0, 1'b0, 1'b0));
      send(mk(FUNC_READ, 0, '0, 1'b0, 1'b0));

      wait_drained();
      repeat (TailCycles) @(posedge clock);
      if (mismatches == 0 && rsp_owed == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* multi_channel_tick_timer_bank.f */
+incdir+src
src/mctt_pkg.sv
src/mctt_ram.sv
src/multi_channel_tick_timer_bank.sv
src/mctt_checker.sv
tb/timer_bank_checker.sv
tb/tb.sv
